// ===== hdl/tqle_pkg.sv =====
// ----------------------------------------------------------------------------
// tqle_pkg
// Shared sizes, types and codes of the tabular Q-learning engine.
// ----------------------------------------------------------------------------
package tqle_pkg;

    localparam int NUM_STATES  = 64;
    localparam int NUM_ACTIONS = 3;
    localparam int ST_W        = $clog2(NUM_STATES);
    localparam int ACT_W       = $clog2(NUM_ACTIONS);
    localparam int Q_W         = 16;
    localparam int CFG_AW      = 3;

    typedef logic signed [Q_W-1:0]           q_t;
    typedef logic [ST_W-1:0]                 st_t;
    typedef logic [ACT_W-1:0]                act_t;
    typedef logic [NUM_ACTIONS-1:0][Q_W-1:0] row_t;

    // commands
    localparam logic [1:0] CMD_OBSERVE = 2'd0;
    localparam logic [1:0] CMD_REWARD  = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;
    localparam logic [1:0] CMD_START   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_LEARN_RATE    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_DISCOUNT      = 3'd1;
    localparam logic [CFG_AW-1:0] REG_EXPLORE_START = 3'd2;
    localparam logic [CFG_AW-1:0] REG_EXPLORE_FLOOR = 3'd3;
    localparam logic [CFG_AW-1:0] REG_EXPLORE_DECAY = 3'd4;
    localparam logic [CFG_AW-1:0] REG_INITIAL_Q     = 3'd5;
    localparam logic [CFG_AW-1:0] REG_Q_FLOOR       = 3'd6;
    localparam logic [CFG_AW-1:0] REG_Q_CEILING     = 3'd7;

    // reset values
    localparam logic [15:0] RST_LEARN_RATE    = 16'd6554;
    localparam logic [15:0] RST_DISCOUNT      = 16'd58982;
    localparam logic [15:0] RST_EXPLORE_START = 16'd65535;
    localparam logic [15:0] RST_EXPLORE_FLOOR = 16'd3277;
    localparam logic [15:0] RST_EXPLORE_DECAY = 16'd64880;
    localparam logic [15:0] RST_INITIAL_Q     = 16'h0000;
    localparam logic [15:0] RST_Q_FLOOR       = 16'h8000;
    localparam logic [15:0] RST_Q_CEILING     = 16'h7FFF;

    // stage strobes of the td datapath
    typedef struct packed {
        logic mul1_en;
        logic mul2_en;
        logic fin_en;
    } td_ctrl_t;

endpackage

// ===== hdl/tqle_row_mem.sv =====
// ----------------------------------------------------------------------------
// tqle_row_mem
// Q table, one row of all action values per word, one write port and two
// registered read ports.
// ----------------------------------------------------------------------------
module tqle_row_mem import tqle_pkg::*;
(
    input  logic clk,
    input  logic we,
    input  st_t  waddr,
    input  row_t wdata,
    input  st_t  raddr_a,
    output row_t rdata_a,
    input  st_t  raddr_b,
    output row_t rdata_b
);

    row_t mem_rows [NUM_STATES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_rows[waddr] <= wdata;
        end
        rdata_a <= mem_rows[raddr_a];
        rdata_b <= mem_rows[raddr_b];
    end

endmodule

// ===== hdl/tqle_td_path.sv =====
// ----------------------------------------------------------------------------
// tqle_td_path
// Temporal difference datapath: discounted max, learning-rate step, clamp.
// Three registered stages, one multiply in each of the first two.
// ----------------------------------------------------------------------------
module tqle_td_path import tqle_pkg::*;
(
    input  logic        clk,
    input  td_ctrl_t    ctrl,
    input  logic [15:0] alpha,
    input  logic [15:0] gamma,
    input  q_t          q_lo,
    input  q_t          q_hi,
    input  q_t          next_max,
    input  q_t          old_q,
    input  q_t          base,
    output q_t          nq
);

    logic signed [32:0] prod1_reg;
    logic signed [36:0] prod2_reg;
    q_t                 old_reg;
    q_t                 base_reg;
    q_t                 nq_reg;

    logic signed [33:0] r1_sum;
    logic signed [17:0] r1;
    logic signed [18:0] target;
    logic signed [19:0] diff;
    logic signed [37:0] r2_sum;
    logic signed [21:0] r2;
    logic signed [22:0] sum_q;
    q_t                 clamped;

    // round to nearest, halves up: floor((x + 2^15) / 2^16)
    assign r1_sum = 34'(prod1_reg) + 34'sd32768;
    assign r1     = $signed(r1_sum[33:16]);
    assign target = 19'(base_reg) + 19'(r1);
    assign diff   = 20'(target) - 20'(old_reg);
    assign r2_sum = 38'(prod2_reg) + 38'sd32768;
    assign r2     = $signed(r2_sum[37:16]);
    assign sum_q  = 23'(old_reg) + 23'(r2);

    always_comb
    begin
        if (sum_q < 23'(q_lo))
        begin
            clamped = q_lo;
        end
        else if (!(sum_q < 23'(q_hi)))
        begin
            clamped = q_hi;
        end
        else
        begin
            clamped = $signed(sum_q[15:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul1_en)
        begin
            prod1_reg <= $signed({1'b0, gamma}) * next_max;
            old_reg   <= old_q;
            base_reg  <= base;
        end
        if (ctrl.mul2_en)
        begin
            prod2_reg <= $signed({1'b0, alpha}) * diff;
        end
        if (ctrl.fin_en)
        begin
            nq_reg <= clamped;
        end
    end

    assign nq = nq_reg;

endmodule

// ===== hdl/tabular_q_learning_engine.sv =====
// ----------------------------------------------------------------------------
// tabular_q_learning_engine
// Tabular Q-learning with epsilon-greedy action choice over a row-wide table.
// ----------------------------------------------------------------------------
// sequence: an item steps through READ, MUL, FIN and DONE; its result is registered
//   on leaving DONE, held while the output stalls; one item at a time, no new one accepted
//   before the row read, both td multiply stages and the table write-back are done
// reset: clears control state, row-seen bits and registers to defaults;
//   table contents need no clearing since a row is seeded on first observation
module tabular_q_learning_engine import tqle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [5:0]        state_index,
    input  logic signed [15:0] reward,
    input  logic signed [15:0] terminal_reward,
    input  logic [15:0]       random_draw,
    input  logic [1:0]        random_pick,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        action,
    output logic              explored,
    output logic              q_updated,
    output logic signed [15:0] new_q,
    output logic [15:0]       explore_now
);

    localparam logic [2:0] FSM_IDLE = 3'd0;
    localparam logic [2:0] FSM_READ = 3'd1;
    localparam logic [2:0] FSM_MUL  = 3'd2;
    localparam logic [2:0] FSM_FIN  = 3'd3;
    localparam logic [2:0] FSM_DONE = 3'd4;

    // configuration
    logic [15:0] learn_rate_reg;
    logic [15:0] discount_reg;
    logic [15:0] explore_floor_reg;
    logic [15:0] explore_decay_reg;
    q_t          initial_q_reg;
    q_t          q_floor_reg;
    q_t          q_ceiling_reg;

    // control state
    logic [2:0]            fsm_reg;
    logic [2:0]            fsm_next;
    logic [NUM_STATES-1:0] seen_reg;
    st_t                   prev_state_reg;
    act_t                  prev_action_reg;
    logic                  have_prev_reg;
    q_t                    reward_sum_reg;
    logic [15:0]           explore_rate_reg;
    logic                  finalized_reg;
    logic                  out_valid_reg;

    // captured item
    logic [1:0]  cmd_reg;
    st_t         s_reg;
    q_t          reward_reg;
    q_t          term_reg;
    logic [15:0] draw_reg;
    logic [1:0]  pick_reg;

    // rows and epsilon product
    row_t        row_s_reg;
    row_t        row_p_reg;
    logic [15:0] eps_dec_reg;

    // output payload
    logic [1:0]  action_reg;
    logic        explored_reg;
    logic        q_updated_reg;
    q_t          new_q_reg;
    logic [15:0] explore_now_reg;

    logic        accept;
    logic        done_go;
    row_t        rd_a;
    row_t        rd_b;
    row_t        row_view;
    q_t          row_max;
    q_t          old_q;
    logic signed [16:0] fin_sum;
    q_t          fin_sat;
    logic signed [16:0] rew_sum;
    q_t          rew_sat;
    logic        is_end;
    logic        upd;
    td_ctrl_t    td_ctrl;
    q_t          td_nq;
    logic        mem_we;
    row_t        mem_wdata;
    row_t        row_p_upd;
    row_t        row_s_upd;
    act_t        greedy_best;
    act_t        pick_act;
    logic        explore_hit;
    act_t        best;
    logic [15:0] eps_after;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (fsm_reg != FSM_IDLE);
    assign done_go  = (fsm_reg == FSM_DONE) && (!out_valid_reg || !out_stall);
    assign is_end   = (cmd_reg == CMD_END);
    assign upd      = have_prev_reg &&
                      ((cmd_reg == CMD_OBSERVE) || (is_end && !finalized_reg));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg    <= RST_LEARN_RATE;
            discount_reg      <= RST_DISCOUNT;
            explore_floor_reg <= RST_EXPLORE_FLOOR;
            explore_decay_reg <= RST_EXPLORE_DECAY;
            initial_q_reg     <= RST_INITIAL_Q;
            q_floor_reg       <= RST_Q_FLOOR;
            q_ceiling_reg     <= RST_Q_CEILING;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEARN_RATE:    learn_rate_reg    <= cfg_data;
                REG_DISCOUNT:      discount_reg      <= cfg_data;
                REG_EXPLORE_START:
                begin
                    // the start value only sets epsilon at reset
                end
                REG_EXPLORE_FLOOR: explore_floor_reg <= cfg_data;
                REG_EXPLORE_DECAY: explore_decay_reg <= cfg_data;
                REG_INITIAL_Q:     initial_q_reg     <= cfg_data;
                REG_Q_FLOOR:       q_floor_reg       <= cfg_data;
                REG_Q_CEILING:     q_ceiling_reg     <= cfg_data;
                default:           learn_rate_reg    <= learn_rate_reg;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            s_reg      <= st_t'(state_index);
            reward_reg <= reward;
            term_reg   <= terminal_reward;
            draw_reg   <= random_draw;
            pick_reg   <= random_pick;
        end
    end

    tqle_row_mem u_row_mem
    (
        .clk     (clk),
        .we      (mem_we),
        .waddr   ((fsm_reg == FSM_READ) ? s_reg : prev_state_reg),
        .wdata   (mem_wdata),
        .raddr_a (st_t'(state_index)),
        .rdata_a (rd_a),
        .raddr_b (prev_state_reg),
        .rdata_b (rd_b)
    );

    // read stage: seeded view of the observed row and its max
    always_comb
    begin
        row_view = seen_reg[s_reg] ? rd_a : row_t'({NUM_ACTIONS{initial_q_reg}});
        row_max  = $signed(row_view[0]);
        for (int i = 1; i < NUM_ACTIONS; i++)
        begin
            if ($signed(row_view[i]) > row_max)
            begin
                row_max = $signed(row_view[i]);
            end
        end
    end

    assign old_q   = $signed(rd_b[prev_action_reg]);
    assign fin_sum = 17'(reward_sum_reg) + 17'(term_reg);
    assign rew_sum = 17'(reward_sum_reg) + 17'(reward_reg);

    always_comb
    begin
        if (fin_sum > 17'sd32767)
        begin
            fin_sat = 16'sh7FFF;
        end
        else if (fin_sum < -17'sd32768)
        begin
            fin_sat = 16'sh8000;
        end
        else
        begin
            fin_sat = $signed(fin_sum[15:0]);
        end
        if (rew_sum > 17'sd32767)
        begin
            rew_sat = 16'sh7FFF;
        end
        else if (rew_sum < -17'sd32768)
        begin
            rew_sat = 16'sh8000;
        end
        else
        begin
            rew_sat = $signed(rew_sum[15:0]);
        end
    end

    assign td_ctrl.mul1_en = (fsm_reg == FSM_READ);
    assign td_ctrl.mul2_en = (fsm_reg == FSM_MUL);
    assign td_ctrl.fin_en  = (fsm_reg == FSM_FIN);

    // a terminal update has no next state, so its max term is zero
    tqle_td_path u_td_path
    (
        .clk      (clk),
        .ctrl     (td_ctrl),
        .alpha    (learn_rate_reg),
        .gamma    (discount_reg),
        .q_lo     (q_floor_reg),
        .q_hi     (q_ceiling_reg),
        .next_max (is_end ? q_t'(0) : row_max),
        .old_q    (old_q),
        .base     (is_end ? fin_sat : reward_sum_reg),
        .nq       (td_nq)
    );

    always_ff @(posedge clk)
    begin
        if (fsm_reg == FSM_READ)
        begin
            row_s_reg   <= row_view;
            row_p_reg   <= rd_b;
            eps_dec_reg <= 16'((32'(explore_rate_reg) * 32'(explore_decay_reg)) >> 16);
        end
    end

    // write-back and decision
    always_comb
    begin
        row_p_upd = row_p_reg;
        row_p_upd[prev_action_reg] = td_nq;
        row_s_upd = row_s_reg;
        if (upd && (prev_state_reg == s_reg))
        begin
            row_s_upd[prev_action_reg] = td_nq;
        end
        greedy_best = '0;
        for (int i = 1; i < NUM_ACTIONS; i++)
        begin
            if ($signed(row_s_upd[i]) > $signed(row_s_upd[greedy_best]))
            begin
                greedy_best = act_t'(i);
            end
        end
    end

    assign pick_act    = (32'(pick_reg) >= NUM_ACTIONS) ?
                         act_t'(32'(pick_reg) - NUM_ACTIONS) : act_t'(pick_reg);
    assign explore_hit = (draw_reg < explore_rate_reg);
    assign best        = explore_hit ? pick_act : greedy_best;

    always_comb
    begin
        eps_after = explore_rate_reg;
        if (is_end && !finalized_reg)
        begin
            eps_after = (eps_dec_reg < explore_floor_reg) ? explore_floor_reg : eps_dec_reg;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = row_p_upd;
        if ((fsm_reg == FSM_READ) && (cmd_reg == CMD_OBSERVE) && !seen_reg[s_reg])
        begin
            mem_we    = 1'b1;
            mem_wdata = row_view;
        end
        else if (done_go && upd)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            FSM_IDLE: if (accept) fsm_next = FSM_READ;
            FSM_READ: fsm_next = FSM_MUL;
            FSM_MUL:  fsm_next = FSM_FIN;
            FSM_FIN:  fsm_next = FSM_DONE;
            FSM_DONE: if (done_go) fsm_next = FSM_IDLE;
            default:  fsm_next = FSM_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg          <= FSM_IDLE;
            seen_reg         <= '0;
            prev_state_reg   <= '0;
            prev_action_reg  <= '0;
            have_prev_reg    <= 1'b0;
            reward_sum_reg   <= '0;
            explore_rate_reg <= RST_EXPLORE_START;
            finalized_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            fsm_reg <= fsm_next;
            if ((fsm_reg == FSM_READ) && (cmd_reg == CMD_OBSERVE))
            begin
                seen_reg[s_reg] <= 1'b1;
            end
            if (done_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (done_go)
            begin
                explore_rate_reg <= eps_after;
                case (cmd_reg)
                    CMD_OBSERVE:
                    begin
                        prev_state_reg  <= s_reg;
                        prev_action_reg <= best;
                        have_prev_reg   <= 1'b1;
                        if (have_prev_reg)
                        begin
                            reward_sum_reg <= '0;
                        end
                    end
                    CMD_REWARD:
                    begin
                        reward_sum_reg <= rew_sat;
                    end
                    CMD_END:
                    begin
                        if (!finalized_reg)
                        begin
                            have_prev_reg   <= 1'b0;
                            prev_state_reg  <= '0;
                            prev_action_reg <= '0;
                            reward_sum_reg  <= '0;
                            finalized_reg   <= 1'b1;
                        end
                    end
                    CMD_START:
                    begin
                        finalized_reg   <= 1'b0;
                        have_prev_reg   <= 1'b0;
                        prev_state_reg  <= '0;
                        prev_action_reg <= '0;
                        reward_sum_reg  <= '0;
                    end
                    default:
                    begin
                        finalized_reg <= finalized_reg;
                    end
                endcase
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (done_go)
        begin
            action_reg      <= (cmd_reg == CMD_OBSERVE) ? 2'(32'(best) + 1) : 2'd0;
            explored_reg    <= (cmd_reg == CMD_OBSERVE) && explore_hit;
            q_updated_reg   <= upd;
            new_q_reg       <= upd ? td_nq : q_t'(0);
            explore_now_reg <= eps_after;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = action_reg;
    assign explored    = explored_reg;
    assign q_updated   = q_updated_reg;
    assign new_q       = new_q_reg;
    assign explore_now = explore_now_reg;

endmodule
